>>> sv/ttt_pkg.sv
// ----------------------------------------------------------------------------
// ttt_pkg: shared types and constants of the timeout table timer
// Field widths, request and result codes, and the records passed to the cells.
// ----------------------------------------------------------------------------
package ttt_pkg;

	localparam int ID_W       = 64;
	localparam int DELAY_W    = 32;
	localparam int CLK_W      = 64;
	localparam int CNT_W      = 7;
	localparam int ACT_W      = 2;
	localparam int KIND_W     = 2;
	localparam int STATUS_W   = 3;
	localparam int MAX_TIMERS_DEF = 64;
	localparam int GRP_SIZE   = 8;
	localparam int GRP_W      = 4;

	localparam logic [ACT_W-1:0] ACT_SCHEDULE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_CANCEL   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_TICK     = 2'd2;

	localparam logic [KIND_W-1:0] KIND_ANSWER = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FIRED  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_IDLE   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ZERO_DELAY = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ARMED      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL       = 3'd3;
	localparam logic [STATUS_W-1:0] ST_UNARMED    = 3'd4;

	// contents of one cell, also what a cell hands to its left neighbor
	typedef struct packed {
		logic             valid;
		logic             due;
		logic [ID_W-1:0]  id;
		logic [CLK_W-1:0] deadline;
	} cell_data_t;

	// command broadcast to every cell of the row
	typedef struct packed {
		logic             append;
		logic             cancel;
		logic             fire;
		logic             mark_due;
		logic [ID_W-1:0]  id;
		logic [CLK_W-1:0] deadline;
		logic [CLK_W-1:0] due_time;
	} cell_ctrl_t;

endpackage

>>> sv/ttt_cell.sv
// ----------------------------------------------------------------------------
// ttt_cell: one slot of the timer row
// Holds one armed timer; compares it against the broadcast id or due time and
// takes its right neighbor's contents when a slot at or left of it is removed.
// ----------------------------------------------------------------------------
module ttt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  ttt_pkg::cell_ctrl_t ctrl,
	input  logic                prev_valid,
	input  logic                rem_in,
	input  ttt_pkg::cell_data_t nxt,
	output ttt_pkg::cell_data_t cur,
	output logic                match,
	output logic                hit,
	output logic                rem_out
);

	logic                      valid_q;
	logic                      due_q;
	logic [ttt_pkg::ID_W-1:0]  id_q;
	logic [ttt_pkg::CLK_W-1:0] deadline_q;
	logic                      shift;
	logic                      load;

	assign match = valid_q && (id_q == ctrl.id);

	// cancel removes the matching slot, fire removes the first due slot
	always_comb begin
		hit = 1'b0;
		if (ctrl.cancel) begin
			hit = match;
		end else if (ctrl.fire) begin
			hit = valid_q && due_q && !rem_in;
		end
	end

	assign rem_out = rem_in || hit;
	assign shift   = (ctrl.cancel || ctrl.fire) && rem_out;
	// first free slot takes the new timer
	assign load    = ctrl.append && !valid_q && prev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			due_q   <= 1'b0;
		end else if (shift) begin
			valid_q <= nxt.valid;
			due_q   <= nxt.due;
		end else if (load) begin
			valid_q <= 1'b1;
			due_q   <= 1'b0;
		end else if (ctrl.mark_due) begin
			due_q <= valid_q && (deadline_q == ctrl.due_time);
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			id_q       <= nxt.id;
			deadline_q <= nxt.deadline;
		end else if (load) begin
			id_q       <= ctrl.id;
			deadline_q <= ctrl.deadline;
		end
	end

	always_comb begin
		cur.valid    = valid_q;
		cur.due      = due_q;
		cur.id       = id_q;
		cur.deadline = deadline_q;
	end

endmodule

>>> sv/timeout_table_timer_core.sv
// ----------------------------------------------------------------------------
// timeout_table_timer_core: table of armed one-shot timeouts with a tick clock
// Timers live in a row of cells kept in arm order; removal closes the gap.
// ----------------------------------------------------------------------------
// Usage: requests enter on in_valid/in_stall with action, timer_id and delay.
// Results leave on out_valid/out_stall from one output register; each request
// gives one or more results and the final one carries last.
// Schedule, cancel and the unused action code each give one answer: the answer is
// written to the output register at the edge that accepts the request. All
// cells compare the id in parallel and the first free cell takes a new timer.
// A tick gives one result per timer that fires, or one idle result when none
// fire: the accepting edge flags due cells, S_GRP counts them in groups of eight,
// S_SUM adds the groups, then S_SCAN hands out the first due cell, one result per
// cycle while the output register is free, and shifts the rest left.
// in_stall is high while a tick is being worked and whenever the output
// register is full and stalled; a stalled result holds and the block waits.
// Reset empties the table, clears the clock and drops any pending result.
// ----------------------------------------------------------------------------
module timeout_table_timer_core #(
	parameter int MAX_TIMERS = ttt_pkg::MAX_TIMERS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [ttt_pkg::ACT_W-1:0]      action,
	input  logic [ttt_pkg::ID_W-1:0]       timer_id,
	input  logic [ttt_pkg::DELAY_W-1:0]    delay,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ttt_pkg::KIND_W-1:0]     kind,
	output logic [ttt_pkg::STATUS_W-1:0]   status,
	output logic [ttt_pkg::ID_W-1:0]       fired_id,
	output logic                           last,
	output logic [ttt_pkg::CLK_W-1:0]      clock_res,
	output logic [ttt_pkg::CNT_W-1:0]      armed_count
);

	localparam int NGRP  = (MAX_TIMERS + ttt_pkg::GRP_SIZE - 1) / ttt_pkg::GRP_SIZE;
	localparam int PAD_W = NGRP * ttt_pkg::GRP_SIZE;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_GRP  = 2'd1;
	localparam logic [1:0] S_SUM  = 2'd2;
	localparam logic [1:0] S_SCAN = 2'd3;

	logic [1:0]                         state_q;
	logic [ttt_pkg::CLK_W-1:0]          clock_q;
	logic [ttt_pkg::CNT_W-1:0]          count_q;
	logic [ttt_pkg::CNT_W-1:0]          final_cnt_q;
	logic [NGRP-1:0][ttt_pkg::GRP_W-1:0] grp_q;

	logic                                out_valid_q;
	logic [ttt_pkg::KIND_W-1:0]          kind_q;
	logic [ttt_pkg::STATUS_W-1:0]        status_q;
	logic [ttt_pkg::ID_W-1:0]            fired_id_q;
	logic                                last_q;
	logic [ttt_pkg::CLK_W-1:0]           clock_res_q;
	logic [ttt_pkg::CNT_W-1:0]           armed_count_q;

	ttt_pkg::cell_ctrl_t                 ctrl;
	ttt_pkg::cell_data_t [MAX_TIMERS:0]  data;
	logic [MAX_TIMERS:0]                 rem;
	logic [MAX_TIMERS-1:0]               match_vec;
	logic [MAX_TIMERS-1:0]               hit_vec;
	logic [MAX_TIMERS-1:0]               due_vec;
	logic [PAD_W-1:0]                    due_pad;

	logic                                out_free;
	logic                                accept;
	logic                                load_ans;
	logic                                load_scan;
	logic                                any_match;
	logic                                any_due;
	logic                                table_full;
	logic [ttt_pkg::STATUS_W-1:0]        ans_status;
	logic [ttt_pkg::CNT_W-1:0]           ans_count;
	logic [ttt_pkg::ID_W-1:0]            hit_id;
	logic                                more_due;
	logic [NGRP-1:0][ttt_pkg::GRP_W-1:0] grp_d;
	logic [ttt_pkg::CNT_W-1:0]           sum_d;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = !((state_q == S_IDLE) && out_free);
	assign accept    = in_valid && !in_stall;
	assign load_ans  = (state_q == S_IDLE) && accept && (action != ttt_pkg::ACT_TICK);
	assign load_scan = (state_q == S_SCAN) && out_free;

	always_comb begin
		for (int i = 0; i < MAX_TIMERS; i++) begin
			due_vec[i] = data[i].valid && data[i].due;
		end
	end

	assign any_match  = |match_vec;
	assign any_due    = |due_vec;
	assign table_full = count_q >= ttt_pkg::CNT_W'(MAX_TIMERS);
	assign more_due   = |(due_vec & ~hit_vec);
	assign due_pad    = PAD_W'(due_vec);

	// command to the row
	always_comb begin
		ctrl.id       = timer_id;
		ctrl.deadline = clock_q + ttt_pkg::CLK_W'(delay);
		ctrl.due_time = clock_q + ttt_pkg::CLK_W'(1);
		ctrl.append   = accept && (action == ttt_pkg::ACT_SCHEDULE) && (delay != '0)
			&& !any_match && !table_full;
		ctrl.cancel   = accept && (action == ttt_pkg::ACT_CANCEL) && any_match;
		ctrl.mark_due = accept && (action == ttt_pkg::ACT_TICK);
		ctrl.fire     = (state_q == S_SCAN) && out_free && any_due;
	end

	assign rem[0]                  = 1'b0;
	assign data[MAX_TIMERS]        = '0;

	for (genvar i = 0; i < MAX_TIMERS; i++) begin : g_cell
		ttt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_valid ((i == 0) ? 1'b1 : data[(i == 0) ? 0 : i - 1].valid),
			.rem_in     (rem[i]),
			.nxt        (data[i + 1]),
			.cur        (data[i]),
			.match      (match_vec[i]),
			.hit        (hit_vec[i]),
			.rem_out    (rem[i + 1])
		);
	end

	// id of the one cell that fires this cycle
	always_comb begin
		hit_id = '0;
		for (int i = 0; i < MAX_TIMERS; i++) begin
			hit_id = hit_id | (data[i].id & {ttt_pkg::ID_W{hit_vec[i]}});
		end
	end

	// answer to schedule, cancel or the unused code
	always_comb begin
		ans_status = ttt_pkg::ST_OK;
		case (action)
			ttt_pkg::ACT_SCHEDULE: begin
				if (delay == '0) begin
					ans_status = ttt_pkg::ST_ZERO_DELAY;
				end else if (any_match) begin
					ans_status = ttt_pkg::ST_ARMED;
				end else if (table_full) begin
					ans_status = ttt_pkg::ST_FULL;
				end
			end
			ttt_pkg::ACT_CANCEL: begin
				if (!any_match) begin
					ans_status = ttt_pkg::ST_UNARMED;
				end
			end
			default: begin
				ans_status = ttt_pkg::ST_OK;
			end
		endcase
		if (ctrl.append) begin
			ans_count = count_q + ttt_pkg::CNT_W'(1);
		end else if (ctrl.cancel) begin
			ans_count = count_q - ttt_pkg::CNT_W'(1);
		end else begin
			ans_count = count_q;
		end
	end

	// due count in groups of eight, then a sum of the groups
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = '0;
			for (int b = 0; b < ttt_pkg::GRP_SIZE; b++) begin
				grp_d[g] = grp_d[g] + ttt_pkg::GRP_W'(due_pad[g * ttt_pkg::GRP_SIZE + b]);
			end
		end
		sum_d = '0;
		for (int g = 0; g < NGRP; g++) begin
			sum_d = sum_d + ttt_pkg::CNT_W'(grp_q[g]);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_GRP) begin
			grp_q <= grp_d;
		end
		if (state_q == S_SUM) begin
			final_cnt_q <= count_q - sum_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			clock_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= load_ans || load_scan || (out_valid_q && out_stall);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (action == ttt_pkg::ACT_TICK) begin
							clock_q <= clock_q + ttt_pkg::CLK_W'(1);
							state_q <= S_GRP;
						end else begin
							count_q <= ans_count;
						end
					end
				end
				S_GRP: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (out_free) begin
						if (any_due) begin
							count_q <= count_q - ttt_pkg::CNT_W'(1);
							if (!more_due) begin
								state_q <= S_IDLE;
							end
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load_ans) begin
			kind_q        <= ttt_pkg::KIND_ANSWER;
			fired_id_q    <= '0;
			last_q        <= 1'b1;
			clock_res_q   <= clock_q;
			status_q      <= ans_status;
			armed_count_q <= ans_count;
		end else if (load_scan) begin
			status_q      <= ttt_pkg::ST_OK;
			clock_res_q   <= clock_q;
			armed_count_q <= final_cnt_q;
			if (any_due) begin
				kind_q     <= ttt_pkg::KIND_FIRED;
				fired_id_q <= hit_id;
				last_q     <= !more_due;
			end else begin
				kind_q     <= ttt_pkg::KIND_IDLE;
				fired_id_q <= '0;
				last_q     <= 1'b1;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign status      = status_q;
	assign fired_id    = fired_id_q;
	assign last        = last_q;
	assign clock_res   = clock_res_q;
	assign armed_count = armed_count_q;

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the timeout table timer core
// Drives schedule, cancel and tick requests through the valid/stall handshake.
// A mirror of the timer table works out the results of every accepted request.
// Each result that leaves the block is compared field by field with the oldest
// one still awaited. Both sides idle at random, and the receiver holds off long
// enough to back the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

	localparam int CYCLE_LIMIT  = 2000000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 100;
	localparam int POOL_SIZE    = 12;
	localparam int PHASE_ITEMS  = 130;
	localparam logic [ttt_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [ttt_pkg::KIND_W-1:0]   kind;
		logic [ttt_pkg::STATUS_W-1:0] status;
		logic [ttt_pkg::ID_W-1:0]     fired_id;
		logic                         last;
		logic [ttt_pkg::CLK_W-1:0]    clock_res;
		logic [ttt_pkg::CNT_W-1:0]    armed_count;
	} timer_result_t;

	// mirror of the timer table: armed timers in arm order plus the tick clock
	class timer_table_mirror;
		logic [ttt_pkg::CLK_W-1:0] tick_now;
		logic [ttt_pkg::ID_W-1:0]  armed_id[$];
		logic [ttt_pkg::CLK_W-1:0] armed_deadline[$];
		timer_result_t             awaited[$];
		int errors;
		int requests;
		int results;
		int fired;
		int peak_armed;
		int answer_hits[5];

		function new();
			tick_now = '0;
			errors = 0;
			requests = 0;
			results = 0;
			fired = 0;
			peak_armed = 0;
			foreach (answer_hits[s])
				answer_hits[s] = 0;
		endfunction

		function int slot_of(logic [ttt_pkg::ID_W-1:0] id);
			foreach (armed_id[i])
				if (armed_id[i] == id)
					return i;
			return -1;
		endfunction

		function timer_result_t make_result(logic [ttt_pkg::KIND_W-1:0] k,
				logic [ttt_pkg::STATUS_W-1:0] st, logic [ttt_pkg::ID_W-1:0] id);
			timer_result_t r;
			r = '0;
			r.kind = k;
			r.status = st;
			r.fired_id = id;
			return r;
		endfunction

		function void apply_request(logic [ttt_pkg::ACT_W-1:0] act,
				logic [ttt_pkg::ID_W-1:0] id, logic [ttt_pkg::DELAY_W-1:0] dly);
			timer_result_t batch[$];
			logic [ttt_pkg::STATUS_W-1:0] st;
			int pos;
			int i;
			st = ttt_pkg::ST_OK;
			pos = slot_of(id);
			requests++;
			case (act)
			ttt_pkg::ACT_SCHEDULE: begin
				// zero delay beats already armed, which beats table full
				if (dly == '0)
					st = ttt_pkg::ST_ZERO_DELAY;
				else if (pos >= 0)
					st = ttt_pkg::ST_ARMED;
				else if (armed_id.size() >= ttt_pkg::MAX_TIMERS_DEF)
					st = ttt_pkg::ST_FULL;
				else begin
					armed_id = {armed_id, id};
					armed_deadline = {armed_deadline, tick_now + ttt_pkg::CLK_W'(dly)};
				end
				answer_hits[st]++;
				batch = {batch, make_result(ttt_pkg::KIND_ANSWER, st, '0)};
			end
			ttt_pkg::ACT_CANCEL: begin
				if (pos < 0)
					st = ttt_pkg::ST_UNARMED;
				else begin
					armed_id.delete(pos);
					armed_deadline.delete(pos);
				end
				answer_hits[st]++;
				batch = {batch, make_result(ttt_pkg::KIND_ANSWER, st, '0)};
			end
			ttt_pkg::ACT_TICK: begin
				tick_now++;
				i = 0;
				while (i < armed_id.size()) begin
					if (armed_deadline[i] == tick_now) begin
						batch = {batch, make_result(ttt_pkg::KIND_FIRED, ttt_pkg::ST_OK,
							armed_id[i])};
						armed_id.delete(i);
						armed_deadline.delete(i);
						fired++;
					end else begin
						i++;
					end
				end
				if (batch.size() == 0)
					batch = {batch, make_result(ttt_pkg::KIND_IDLE, ttt_pkg::ST_OK, '0)};
			end
			default: begin
				batch = {batch, make_result(ttt_pkg::KIND_ANSWER, ttt_pkg::ST_OK, '0)};
			end
			endcase
			batch[batch.size() - 1].last = 1'b1;
			foreach (batch[j]) begin
				batch[j].clock_res = tick_now;
				batch[j].armed_count = ttt_pkg::CNT_W'(armed_id.size());
				awaited = {awaited, batch[j]};
			end
			if (armed_id.size() > peak_armed)
				peak_armed = armed_id.size();
		endfunction

		function void check_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s mismatch: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void compare_result(timer_result_t got);
			timer_result_t want;
			if (awaited.size() == 0) begin
				$error("result with nothing awaited: kind %0d fired_id %0h", got.kind,
					got.fired_id);
				errors++;
				return;
			end
			want = awaited.pop_front();
			results++;
			check_field("kind", 64'(want.kind), 64'(got.kind));
			check_field("status", 64'(want.status), 64'(got.status));
			check_field("fired_id", want.fired_id, got.fired_id);
			check_field("last", 64'(want.last), 64'(got.last));
			check_field("clock_res", want.clock_res, got.clock_res);
			check_field("armed_count", 64'(want.armed_count), 64'(got.armed_count));
		endfunction
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	logic [ttt_pkg::ACT_W-1:0]    action;
	logic [ttt_pkg::ID_W-1:0]     timer_id;
	logic [ttt_pkg::DELAY_W-1:0]  delay;
	logic                         out_valid;
	logic                         out_stall;
	logic [ttt_pkg::KIND_W-1:0]   kind;
	logic [ttt_pkg::STATUS_W-1:0] status;
	logic [ttt_pkg::ID_W-1:0]     fired_id;
	logic                         last;
	logic [ttt_pkg::CLK_W-1:0]    clock_res;
	logic [ttt_pkg::CNT_W-1:0]    armed_count;

	timer_table_mirror        mirror = new();
	logic [ttt_pkg::ID_W-1:0] id_pool[POOL_SIZE];
	int                       src_idle_pct;
	int                       sink_stall_pct;
	logic                     hold_wanted;
	int                       held_cycles;
	int                       cycle_count;

	timeout_table_timer_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.timer_id    (timer_id),
		.delay       (delay),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.status      (status),
		.fired_id    (fired_id),
		.last        (last),
		.clock_res   (clock_res),
		.armed_count (armed_count)
	);

	always #5 clk = ~clk;

	// one request: optional idle gap, then hold the payload until accepted
	task automatic send_request(logic [ttt_pkg::ACT_W-1:0] act, logic [ttt_pkg::ID_W-1:0] id,
			logic [ttt_pkg::DELAY_W-1:0] dly);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		action   <= act;
		timer_id <= id;
		delay    <= dly;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		mirror.apply_request(act, id, dly);
		@(negedge clk);
	endtask

	task automatic send_ticks(int n);
		repeat (n)
			send_request(ttt_pkg::ACT_TICK, {$urandom, $urandom}, $urandom);
	endtask

	function automatic logic [ttt_pkg::ID_W-1:0] pick_id();
		int roll;
		roll = $urandom_range(9);
		if (roll < 2)
			return {$urandom, $urandom};
		if (roll < 4 && mirror.armed_id.size() > 0)
			return mirror.armed_id[$urandom_range(mirror.armed_id.size() - 1)];
		return id_pool[$urandom_range(POOL_SIZE - 1)];
	endfunction

	// arm until the table is full, poke the rejections, then let them fire
	task automatic fill_table();
		int spread;
		spread = $urandom_range(2);
		while (mirror.armed_id.size() < ttt_pkg::MAX_TIMERS_DEF)
			send_request(ttt_pkg::ACT_SCHEDULE, {$urandom, $urandom},
				ttt_pkg::DELAY_W'($urandom_range(1, 1 + spread)));
		send_request(ttt_pkg::ACT_SCHEDULE, {$urandom, $urandom},
			ttt_pkg::DELAY_W'($urandom_range(1, 3)));
		send_request(ttt_pkg::ACT_SCHEDULE,
			mirror.armed_id[$urandom_range(ttt_pkg::MAX_TIMERS_DEF - 1)],
			ttt_pkg::DELAY_W'($urandom_range(1, 9)));
		send_request(ttt_pkg::ACT_SCHEDULE, {$urandom, $urandom}, '0);
		send_ticks(3);
	endtask

	task automatic random_sequence();
		int roll;
		int k;
		roll = $urandom_range(99);
		if (roll < 4)
			fill_table();
		else if (roll < 50) begin
			// a few arms with short delays, maybe a cancel, then ticks to fire them
			repeat ($urandom_range(1, 6))
				send_request(ttt_pkg::ACT_SCHEDULE, pick_id(),
					ttt_pkg::DELAY_W'($urandom_range(1, 6)));
			if ($urandom_range(2) == 0)
				send_request(ttt_pkg::ACT_CANCEL, pick_id(), $urandom);
			send_ticks($urandom_range(1, 7));
		end else if (roll < 65)
			send_ticks($urandom_range(1, 4));
		else if (roll < 78)
			send_request(ttt_pkg::ACT_CANCEL, pick_id(), $urandom);
		else begin
			k = $urandom_range(2);
			send_request(ttt_pkg::ACT_W'($urandom_range(3)), pick_id(),
				k == 0 ? ttt_pkg::DELAY_W'(0) :
				(k == 1 ? $urandom : ttt_pkg::DELAY_W'($urandom_range(1, 9))));
		end
	endtask

	// receiver: random stall, or one long hold-off when asked
	initial begin : result_sink
		int hold_left;
		logic hold_taken;
		hold_left = 0;
		hold_taken = 1'b0;
		held_cycles = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_wanted && !hold_taken) begin
				hold_left = HOLD_CYCLES;
				hold_taken = 1'b1;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
				held_cycles++;
			end else begin
				out_stall <= ($urandom_range(99) < sink_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
			mirror.compare_result(timer_result_t'({kind, status, fired_id, last, clock_res,
				armed_count}));
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$error("timeout after %0d cycles, %0d results still awaited", cycle_count,
			mirror.awaited.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		logic [ttt_pkg::ID_W-1:0] id_a;
		logic [ttt_pkg::ID_W-1:0] id_b;
		int target;
		id_a = 64'h0123_4567_89ab_cdef;
		id_b = 64'h8000_0000_0000_0001;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ttt_pkg::ACT_SCHEDULE;
		timer_id = '0;
		delay = '0;
		hold_wanted = 1'b0;
		src_idle_pct = 22;
		sink_stall_pct = 83;
		id_pool[0] = '0;
		id_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			id_pool[i] = {$urandom, $urandom};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty tick, unused code, zero delay, armed and unarmed cancel rejections, firing order
		send_ticks(1);
		send_request(ACT_UNUSED, '1, '1);
		send_request(ttt_pkg::ACT_SCHEDULE, '0, '0);
		send_request(ttt_pkg::ACT_SCHEDULE, '0, 32'd1);
		send_request(ttt_pkg::ACT_SCHEDULE, '0, 32'd7);
		send_request(ttt_pkg::ACT_SCHEDULE, '1, '1);
		send_request(ttt_pkg::ACT_SCHEDULE, id_a, 32'd1);
		send_request(ttt_pkg::ACT_SCHEDULE, id_b, 32'd2);
		send_request(ttt_pkg::ACT_CANCEL, 64'h5555_aaaa_5555_aaaa, '0);
		send_ticks(1);
		send_request(ttt_pkg::ACT_CANCEL, '1, '0);
		send_request(ttt_pkg::ACT_CANCEL, '1, '0);
		send_request(ttt_pkg::ACT_SCHEDULE, id_b, 32'd4);
		send_ticks(1);
		// a re-armed id moves to the end of the arm order
		send_request(ttt_pkg::ACT_SCHEDULE, 64'd5, 32'd3);
		send_request(ttt_pkg::ACT_SCHEDULE, 64'd6, 32'd1);
		send_request(ttt_pkg::ACT_SCHEDULE, 64'd7, 32'd3);
		send_request(ttt_pkg::ACT_CANCEL, 64'd6, '0);
		send_request(ttt_pkg::ACT_SCHEDULE, 64'd6, 32'd3);
		send_ticks(3);

		target = mirror.requests + PHASE_ITEMS;
		while (mirror.requests < target)
			random_sequence();

		src_idle_pct = 83;
		sink_stall_pct = 22;
		target = mirror.requests + PHASE_ITEMS;
		while (mirror.requests < target)
			random_sequence();

		// no idling; receiver backs off while the table fills
		src_idle_pct = 0;
		sink_stall_pct = 0;
		hold_wanted <= 1'b1;
		fill_table();
		target = mirror.requests + PHASE_ITEMS;
		while (mirror.requests < target)
			random_sequence();
		in_valid <= 1'b0;

		while (mirror.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests, %0d results, %0d timers fired, up to %0d armed",
			mirror.requests, mirror.results, mirror.fired, mirror.peak_armed);
		$display("rejects: zero delay %0d, armed %0d, full %0d, unarmed cancel %0d; hold %0d",
			mirror.answer_hits[ttt_pkg::ST_ZERO_DELAY], mirror.answer_hits[ttt_pkg::ST_ARMED],
			mirror.answer_hits[ttt_pkg::ST_FULL], mirror.answer_hits[ttt_pkg::ST_UNARMED],
			held_cycles);
		if (mirror.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
